### design/sprite_quad_vertex_setup_assert.svh
// assertion macros used by the sprite quad vertex setup checker
`ifndef SPRITE_QUAD_VERTEX_SETUP_ASSERT_SVH
`define SPRITE_QUAD_VERTEX_SETUP_ASSERT_SVH

// condition in one cycle implies a condition in the next, skipped during reset
`define SQVS_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("sqvs check failed");

// state seen in the cycle after reset is held
`define SQVS_ASSERT_AFTER_RESET(lbl, clk, rst, cons) \
   lbl: assert property (@(posedge clk) (rst) |=> (cons)) \
      else $error("sqvs reset check failed");

`endif

### design/sqvs_pkg.sv
// shared types, constants and helpers for the sprite quad vertex setup block
package sqvs_pkg;

   // configuration registers
   localparam int CFG_W       = 9;
   localparam int CSR_INDEX_W = 1;
   localparam logic [CSR_INDEX_W-1:0] CSR_CELL_WIDTH  = 1'b0;
   localparam logic [CSR_INDEX_W-1:0] CSR_CELL_HEIGHT = 1'b1;
   localparam logic [CFG_W-1:0]       CELL_SIZE_RESET = 9'd32;

   // field widths
   localparam int COEF_W  = 16;
   localparam int SHIFT_W = 24;
   localparam int POS_W   = 32;

   // fixed point scaling: world in 2^-19 pixel, matrix terms shifted by 5
   localparam int WORLD_SHIFT = 19;
   localparam int MAT_SHIFT   = 5;
   localparam int ROUND_SHIFT = 11;
   localparam int ROUND_HALF  = 1024;

   // queue depths between the parts
   localparam int MID_DEPTH = 4;
   localparam int OUT_DEPTH = 4;

   // vertex sequencing
   localparam int VTX_W = 3;
   localparam logic [VTX_W-1:0] LAST_VTX = 3'd5;

   typedef struct packed {
      logic [CFG_W-1:0] cell_width;
      logic [CFG_W-1:0] cell_height;
   } cfg_type;

   typedef enum logic [1:0] {
      CORNER_TL,
      CORNER_TR,
      CORNER_BR,
      CORNER_BL
   } corner_type;

   // two triangles: TL, TR, BR, TL, BR, BL
   function automatic corner_type corner_of(logic [VTX_W-1:0] vtx);
      corner_type c;
      case (vtx)
         3'd0:    c = CORNER_TL;
         3'd1:    c = CORNER_TR;
         3'd2:    c = CORNER_BR;
         3'd3:    c = CORNER_TL;
         3'd4:    c = CORNER_BR;
         3'd5:    c = CORNER_BL;
         default: c = CORNER_TL;
      endcase
      return c;
   endfunction

endpackage

### design/sqvs_fifo.sv
// small register queue with count, used between front and back and at the output
module sqvs_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         push,
   input  logic [WIDTH-1:0]             push_data,
   input  logic                         pop,
   output logic [WIDTH-1:0]             pop_data,
   output logic                         empty,
   output logic [$clog2(DEPTH+1)-1:0]   count
);

   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH+1);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             pop_ok;

   assign empty    = (count_ff == '0);
   assign count    = count_ff;
   assign pop_data = mem_ff[rd_ptr_ff];
   assign pop_ok   = pop && !empty;

   // pointer and count update, pushes only arrive when space was reserved
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH-1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop_ok) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH-1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      count_in = count_ff + CNT_W'(push) - CNT_W'(pop_ok);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // storage
   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

### design/sqvs_front.sv
// front part: takes a tile request and forms its per-tile products and base positions
module sqvs_front #(
   parameter int COORD_BITS = 12
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  sqvs_pkg::cfg_type                      cfg,
   input  logic                                   push,
   output logic                                   full,
   input  logic [COORD_BITS-1:0]                  tile_col,
   input  logic [COORD_BITS-1:0]                  tile_row,
   input  logic [COORD_BITS-1:0]                  src_left,
   input  logic [COORD_BITS-1:0]                  src_top,
   input  logic [COORD_BITS-1:0]                  src_width,
   input  logic [COORD_BITS-1:0]                  src_height,
   input  logic signed [sqvs_pkg::COEF_W-1:0]     m_xx,
   input  logic signed [sqvs_pkg::COEF_W-1:0]     m_xy,
   input  logic signed [sqvs_pkg::COEF_W-1:0]     m_yx,
   input  logic signed [sqvs_pkg::COEF_W-1:0]     m_yy,
   input  logic signed [sqvs_pkg::SHIFT_W-1:0]    shift_x,
   input  logic signed [sqvs_pkg::SHIFT_W-1:0]    shift_y,
   input  logic [$clog2(sqvs_pkg::MID_DEPTH+1)-1:0] mid_count,
   output logic                                   ent_valid,
   output logic signed [COORD_BITS+31:0]          ent_base_x,
   output logic signed [COORD_BITS+31:0]          ent_base_y,
   output logic signed [COORD_BITS+16:0]          ent_axw,
   output logic signed [COORD_BITS+16:0]          ent_bxh,
   output logic signed [COORD_BITS+16:0]          ent_ayw,
   output logic signed [COORD_BITS+16:0]          ent_byh,
   output logic [COORD_BITS:0]                    ent_left,
   output logic [COORD_BITS:0]                    ent_top,
   output logic [COORD_BITS:0]                    ent_right,
   output logic [COORD_BITS:0]                    ent_bottom
);

   localparam int ACC_W   = COORD_BITS + 32;
   localparam int PW      = COORD_BITS + 17;
   localparam int TEX_W   = COORD_BITS + 1;
   localparam int WORLD_W = COORD_BITS + sqvs_pkg::CFG_W;
   localparam int TP_W    = sqvs_pkg::SHIFT_W + sqvs_pkg::CFG_W + 1;
   localparam int CNT_W   = $clog2(sqvs_pkg::MID_DEPTH+1);

   logic              accept;
   logic [CNT_W:0]    pending;

   logic              s1_valid_ff;
   logic [WORLD_W-1:0] world_x_ff, world_x_in;
   logic [WORLD_W-1:0] world_y_ff, world_y_in;
   logic signed [TP_W-1:0] trans_x_ff, trans_x_in;
   logic signed [TP_W-1:0] trans_y_ff, trans_y_in;
   logic signed [PW-1:0] axw_ff, axw_in;
   logic signed [PW-1:0] bxh_ff, bxh_in;
   logic signed [PW-1:0] ayw_ff, ayw_in;
   logic signed [PW-1:0] byh_ff, byh_in;
   logic [TEX_W-1:0]  left_ff, top_ff, right_ff, bottom_ff;
   logic [TEX_W-1:0]  right_in, bottom_in;

   logic              s2_valid_ff;
   logic signed [ACC_W-1:0] base_x_ff, base_x_in;
   logic signed [ACC_W-1:0] base_y_ff, base_y_in;
   logic signed [PW-1:0] axw2_ff, bxh2_ff, ayw2_ff, byh2_ff;
   logic [TEX_W-1:0]  left2_ff, top2_ff, right2_ff, bottom2_ff;

   logic signed [TP_W-1:0] cw_s;
   logic signed [PW-1:0]   w_s, h_s;
   logic signed [ACC_W-1:0] wx_s, wy_s, tx_s, ty_s;

   // space is reserved in the queue for every tile still in the front stages
   assign pending = {1'b0, mid_count} + (CNT_W+1)'(s1_valid_ff) + (CNT_W+1)'(s2_valid_ff);
   assign full    = (pending >= (CNT_W+1)'(sqvs_pkg::MID_DEPTH));
   assign accept  = push && !full;

   // stage 1: tile placement, translation and matrix products
   always_comb begin
      cw_s       = TP_W'($signed({1'b0, cfg.cell_width}));
      w_s        = PW'($signed({1'b0, src_width}));
      h_s        = PW'($signed({1'b0, src_height}));
      world_x_in = WORLD_W'(tile_col) * WORLD_W'(cfg.cell_width);
      world_y_in = WORLD_W'(tile_row) * WORLD_W'(cfg.cell_height);
      // both translations scale by the cell width
      trans_x_in = TP_W'(shift_x) * cw_s;
      trans_y_in = TP_W'(shift_y) * cw_s;
      axw_in     = PW'(m_xx) * w_s;
      bxh_in     = PW'(m_xy) * h_s;
      ayw_in     = PW'(m_yx) * w_s;
      byh_in     = PW'(m_yy) * h_s;
      right_in   = TEX_W'(src_left) + TEX_W'(src_width);
      bottom_in  = TEX_W'(src_top) + TEX_W'(src_height);
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         world_x_ff <= world_x_in;
         world_y_ff <= world_y_in;
         trans_x_ff <= trans_x_in;
         trans_y_ff <= trans_y_in;
         axw_ff     <= axw_in;
         bxh_ff     <= bxh_in;
         ayw_ff     <= ayw_in;
         byh_ff     <= byh_in;
         left_ff    <= TEX_W'(src_left);
         top_ff     <= TEX_W'(src_top);
         right_ff   <= right_in;
         bottom_ff  <= bottom_in;
      end
   end

   // stage 2: base position = world in 2^-19 pixel plus translation times 25
   always_comb begin
      wx_s      = $signed(ACC_W'(world_x_ff));
      wy_s      = $signed(ACC_W'(world_y_ff));
      tx_s      = ACC_W'(trans_x_ff);
      ty_s      = ACC_W'(trans_y_ff);
      base_x_in = (wx_s <<< sqvs_pkg::WORLD_SHIFT) + (tx_s <<< 4) + (tx_s <<< 3) + tx_s;
      base_y_in = (wy_s <<< sqvs_pkg::WORLD_SHIFT) + (ty_s <<< 4) + (ty_s <<< 3) + ty_s;
   end

   always_ff @(posedge clock) begin
      if (s1_valid_ff) begin
         base_x_ff  <= base_x_in;
         base_y_ff  <= base_y_in;
         axw2_ff    <= axw_ff;
         bxh2_ff    <= bxh_ff;
         ayw2_ff    <= ayw_ff;
         byh2_ff    <= byh_ff;
         left2_ff   <= left_ff;
         top2_ff    <= top_ff;
         right2_ff  <= right_ff;
         bottom2_ff <= bottom_ff;
      end
   end

   // stage valids
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= accept;
         s2_valid_ff <= s1_valid_ff;
      end
   end

   assign ent_valid  = s2_valid_ff;
   assign ent_base_x = base_x_ff;
   assign ent_base_y = base_y_ff;
   assign ent_axw    = axw2_ff;
   assign ent_bxh    = bxh2_ff;
   assign ent_ayw    = ayw2_ff;
   assign ent_byh    = byh2_ff;
   assign ent_left   = left2_ff;
   assign ent_top    = top2_ff;
   assign ent_right  = right2_ff;
   assign ent_bottom = bottom2_ff;

endmodule

### design/sqvs_back.sv
// back part: walks the six vertices of each queued tile and rounds the positions
module sqvs_back #(
   parameter int COORD_BITS = 12
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              head_valid,
   output logic                              head_pop,
   input  logic signed [COORD_BITS+31:0]     head_base_x,
   input  logic signed [COORD_BITS+31:0]     head_base_y,
   input  logic signed [COORD_BITS+16:0]     head_axw,
   input  logic signed [COORD_BITS+16:0]     head_bxh,
   input  logic signed [COORD_BITS+16:0]     head_ayw,
   input  logic signed [COORD_BITS+16:0]     head_byh,
   input  logic [COORD_BITS:0]               head_left,
   input  logic [COORD_BITS:0]               head_top,
   input  logic [COORD_BITS:0]               head_right,
   input  logic [COORD_BITS:0]               head_bottom,
   output logic                              empty,
   input  logic                              pop,
   output logic signed [sqvs_pkg::POS_W-1:0] rsp_pos_x,
   output logic signed [sqvs_pkg::POS_W-1:0] rsp_pos_y,
   output logic [COORD_BITS:0]               rsp_tex_u,
   output logic [COORD_BITS:0]               rsp_tex_v,
   output logic                              rsp_last_vertex
);

   localparam int ACC_W = COORD_BITS + 32;
   localparam int PW    = COORD_BITS + 17;
   localparam int TEX_W = COORD_BITS + 1;
   localparam int POS_W = sqvs_pkg::POS_W;
   localparam int RW    = ACC_W - sqvs_pkg::ROUND_SHIFT;
   localparam int EXT_W = (RW > POS_W) ? RW : POS_W + 1;
   localparam int CNT_W = $clog2(sqvs_pkg::OUT_DEPTH+1);
   localparam int OUT_W = 2 * POS_W + 2 * TEX_W + 1;
   localparam logic signed [EXT_W-1:0] SAT_MAX = EXT_W'(64'sh7fffffff);
   localparam logic signed [EXT_W-1:0] SAT_MIN = EXT_W'(-64'sh80000000);

   logic [sqvs_pkg::VTX_W-1:0] vtx_ff, vtx_in;
   logic                 issue;
   logic                 is_last;
   logic [CNT_W:0]       out_pending;
   logic [CNT_W-1:0]     out_count;
   sqvs_pkg::corner_type corner;
   logic                 use_w, use_h;
   logic signed [PW:0]   lin_x, lin_y;

   logic                 v1_valid_ff;
   logic signed [ACC_W-1:0] sum_x_ff, sum_x_in;
   logic signed [ACC_W-1:0] sum_y_ff, sum_y_in;
   logic [TEX_W-1:0]     tex_u_ff, tex_u_in;
   logic [TEX_W-1:0]     tex_v_ff, tex_v_in;
   logic                 last_ff;

   logic [POS_W-1:0]     pos_x_rnd, pos_y_rnd;
   logic [OUT_W-1:0]     out_wr, out_rd;

   // round half up to Q24.8 and clamp to the signed 32-bit range
   function automatic logic [POS_W-1:0] round_sat(logic signed [ACC_W-1:0] v);
      logic signed [ACC_W-1:0] t;
      logic signed [RW-1:0]    q;
      logic signed [EXT_W-1:0] q_ext;
      logic [POS_W-1:0]        r;
      t     = v + ACC_W'(sqvs_pkg::ROUND_HALF);
      q     = t[ACC_W-1:sqvs_pkg::ROUND_SHIFT];
      q_ext = EXT_W'(q);
      if (q_ext > SAT_MAX) begin
         r = SAT_MAX[POS_W-1:0];
      end else if (q_ext < SAT_MIN) begin
         r = SAT_MIN[POS_W-1:0];
      end else begin
         r = q_ext[POS_W-1:0];
      end
      return r;
   endfunction

   // issue a vertex only when the output queue has room for it
   assign out_pending = {1'b0, out_count} + (CNT_W+1)'(v1_valid_ff);
   assign issue       = head_valid && (out_pending < (CNT_W+1)'(sqvs_pkg::OUT_DEPTH));
   assign is_last     = (vtx_ff == sqvs_pkg::LAST_VTX);
   assign head_pop    = issue && is_last;

   // vertex counter
   always_comb begin
      vtx_in = vtx_ff;
      if (issue) begin
         vtx_in = is_last ? '0 : vtx_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vtx_ff      <= '0;
         v1_valid_ff <= 1'b0;
      end else begin
         vtx_ff      <= vtx_in;
         v1_valid_ff <= issue;
      end
   end

   // corner selection: which source edges this vertex sits on
   always_comb begin
      corner = sqvs_pkg::corner_of(vtx_ff);
      case (corner)
         sqvs_pkg::CORNER_TL: begin
            use_w = 1'b0;
            use_h = 1'b0;
         end
         sqvs_pkg::CORNER_TR: begin
            use_w = 1'b1;
            use_h = 1'b0;
         end
         sqvs_pkg::CORNER_BR: begin
            use_w = 1'b1;
            use_h = 1'b1;
         end
         sqvs_pkg::CORNER_BL: begin
            use_w = 1'b0;
            use_h = 1'b1;
         end
         default: begin
            use_w = 1'b0;
            use_h = 1'b0;
         end
      endcase
   end

   // vertex position in 2^-19 pixel
   always_comb begin
      lin_x    = (use_w ? (PW+1)'(head_axw) : '0) + (use_h ? (PW+1)'(head_bxh) : '0);
      lin_y    = (use_w ? (PW+1)'(head_ayw) : '0) + (use_h ? (PW+1)'(head_byh) : '0);
      sum_x_in = head_base_x + (ACC_W'(lin_x) <<< sqvs_pkg::MAT_SHIFT);
      sum_y_in = head_base_y + (ACC_W'(lin_y) <<< sqvs_pkg::MAT_SHIFT);
      tex_u_in = use_w ? head_right : head_left;
      tex_v_in = use_h ? head_bottom : head_top;
   end

   always_ff @(posedge clock) begin
      if (issue) begin
         sum_x_ff <= sum_x_in;
         sum_y_ff <= sum_y_in;
         tex_u_ff <= tex_u_in;
         tex_v_ff <= tex_v_in;
         last_ff  <= is_last;
      end
   end

   // rounding into the output queue
   assign pos_x_rnd = round_sat(sum_x_ff);
   assign pos_y_rnd = round_sat(sum_y_ff);
   assign out_wr    = {pos_x_rnd, pos_y_rnd, tex_u_ff, tex_v_ff, last_ff};

   sqvs_fifo #(
      .WIDTH (OUT_W),
      .DEPTH (sqvs_pkg::OUT_DEPTH)
   ) u_out_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (v1_valid_ff),
      .push_data (out_wr),
      .pop       (pop),
      .pop_data  (out_rd),
      .empty     (empty),
      .count     (out_count)
   );

   assign {rsp_pos_x, rsp_pos_y, rsp_tex_u, rsp_tex_v, rsp_last_vertex} = out_rd;

endmodule

### design/sprite_quad_vertex_setup.sv
// top level of the sprite quad vertex setup block
//
// Each request is one map tile: grid column and row, a source rectangle in
// the atlas, a 2x2 Q2.14 transform and a Q8.16 translation. Each tile turns
// into six vertices (TL, TR, BR, TL, BR, BL) with a Q24.8 position and an
// atlas coordinate; last_vertex marks the sixth.
// Request side: a request is taken at a clock edge with push high and full
// low. Result side: the oldest vertex sits on the rsp_ ports while empty is
// low and leaves at an edge with pop high.
// Registers cell_width (index 0) and cell_height (index 1) are written
// through csr_write/csr_index/csr_data. The user must write them only while
// the block is idle; the block itself does not enforce this. A tile passes
// the front stages, the tile queue, the back's vertex register and the
// output queue, and the back emits one vertex per cycle while there is room.
// A four-entry queue holds tiles between the front and the back, so the next
// requests are taken while earlier tiles are still being emitted.
// Reset (synchronous) empties both queues and sets both cell sizes to 32.
// When pop stays low the output queue fills, the back stops issuing, the
// tile queue fills and full rises; nothing is dropped.
module sprite_quad_vertex_setup #(
   parameter int COORD_BITS = 12
) (
   input  logic                                  clock,
   input  logic                                  reset,
   // request channel
   input  logic                                  push,
   output logic                                  full,
   input  logic [COORD_BITS-1:0]                 req_tile_col,
   input  logic [COORD_BITS-1:0]                 req_tile_row,
   input  logic [COORD_BITS-1:0]                 req_src_left,
   input  logic [COORD_BITS-1:0]                 req_src_top,
   input  logic [COORD_BITS-1:0]                 req_src_width,
   input  logic [COORD_BITS-1:0]                 req_src_height,
   input  logic signed [sqvs_pkg::COEF_W-1:0]    req_m_xx,
   input  logic signed [sqvs_pkg::COEF_W-1:0]    req_m_xy,
   input  logic signed [sqvs_pkg::COEF_W-1:0]    req_m_yx,
   input  logic signed [sqvs_pkg::COEF_W-1:0]    req_m_yy,
   input  logic signed [sqvs_pkg::SHIFT_W-1:0]   req_shift_x,
   input  logic signed [sqvs_pkg::SHIFT_W-1:0]   req_shift_y,
   // result channel
   output logic                                  empty,
   input  logic                                  pop,
   output logic signed [sqvs_pkg::POS_W-1:0]     rsp_pos_x,
   output logic signed [sqvs_pkg::POS_W-1:0]     rsp_pos_y,
   output logic [COORD_BITS:0]                   rsp_tex_u,
   output logic [COORD_BITS:0]                   rsp_tex_v,
   output logic                                  rsp_last_vertex,
   // configuration
   input  logic                                  csr_write,
   input  logic [sqvs_pkg::CSR_INDEX_W-1:0]      csr_index,
   input  logic [sqvs_pkg::CFG_W-1:0]            csr_data
);

   localparam int ACC_W = COORD_BITS + 32;
   localparam int PW    = COORD_BITS + 17;
   localparam int TEX_W = COORD_BITS + 1;
   localparam int MID_W = 2 * ACC_W + 4 * PW + 4 * TEX_W;
   localparam int CNT_W = $clog2(sqvs_pkg::MID_DEPTH+1);

   logic [sqvs_pkg::CFG_W-1:0] cell_width_ff, cell_width_in;
   logic [sqvs_pkg::CFG_W-1:0] cell_height_ff, cell_height_in;
   sqvs_pkg::cfg_type cfg;

   logic                    f_valid;
   logic signed [ACC_W-1:0] f_base_x, f_base_y;
   logic signed [PW-1:0]    f_axw, f_bxh, f_ayw, f_byh;
   logic [TEX_W-1:0]        f_left, f_top, f_right, f_bottom;

   logic signed [ACC_W-1:0] b_base_x, b_base_y;
   logic signed [PW-1:0]    b_axw, b_bxh, b_ayw, b_byh;
   logic [TEX_W-1:0]        b_left, b_top, b_right, b_bottom;

   logic [MID_W-1:0] mid_wr, mid_rd;
   logic             mid_empty;
   logic             mid_pop;
   logic [CNT_W-1:0] mid_count;

   // configuration registers
   always_comb begin
      cell_width_in  = cell_width_ff;
      cell_height_in = cell_height_ff;
      if (csr_write) begin
         case (csr_index)
            sqvs_pkg::CSR_CELL_WIDTH:  cell_width_in  = csr_data;
            sqvs_pkg::CSR_CELL_HEIGHT: cell_height_in = csr_data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cell_width_ff  <= sqvs_pkg::CELL_SIZE_RESET;
         cell_height_ff <= sqvs_pkg::CELL_SIZE_RESET;
      end else begin
         cell_width_ff  <= cell_width_in;
         cell_height_ff <= cell_height_in;
      end
   end

   assign cfg.cell_width  = cell_width_ff;
   assign cfg.cell_height = cell_height_ff;

   // front: per-tile products
   sqvs_front #(
      .COORD_BITS (COORD_BITS)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg),
      .push       (push),
      .full       (full),
      .tile_col   (req_tile_col),
      .tile_row   (req_tile_row),
      .src_left   (req_src_left),
      .src_top    (req_src_top),
      .src_width  (req_src_width),
      .src_height (req_src_height),
      .m_xx       (req_m_xx),
      .m_xy       (req_m_xy),
      .m_yx       (req_m_yx),
      .m_yy       (req_m_yy),
      .shift_x    (req_shift_x),
      .shift_y    (req_shift_y),
      .mid_count  (mid_count),
      .ent_valid  (f_valid),
      .ent_base_x (f_base_x),
      .ent_base_y (f_base_y),
      .ent_axw    (f_axw),
      .ent_bxh    (f_bxh),
      .ent_ayw    (f_ayw),
      .ent_byh    (f_byh),
      .ent_left   (f_left),
      .ent_top    (f_top),
      .ent_right  (f_right),
      .ent_bottom (f_bottom)
   );

   // tile queue between front and back
   assign mid_wr = {f_base_x, f_base_y, f_axw, f_bxh, f_ayw, f_byh,
                    f_left, f_top, f_right, f_bottom};

   sqvs_fifo #(
      .WIDTH (MID_W),
      .DEPTH (sqvs_pkg::MID_DEPTH)
   ) u_tile_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (f_valid),
      .push_data (mid_wr),
      .pop       (mid_pop),
      .pop_data  (mid_rd),
      .empty     (mid_empty),
      .count     (mid_count)
   );

   assign {b_base_x, b_base_y, b_axw, b_bxh, b_ayw, b_byh,
           b_left, b_top, b_right, b_bottom} = mid_rd;

   // back: vertex walk and output queue
   sqvs_back #(
      .COORD_BITS (COORD_BITS)
   ) u_back (
      .clock           (clock),
      .reset           (reset),
      .head_valid      (!mid_empty),
      .head_pop        (mid_pop),
      .head_base_x     (b_base_x),
      .head_base_y     (b_base_y),
      .head_axw        (b_axw),
      .head_bxh        (b_bxh),
      .head_ayw        (b_ayw),
      .head_byh        (b_byh),
      .head_left       (b_left),
      .head_top        (b_top),
      .head_right      (b_right),
      .head_bottom     (b_bottom),
      .empty           (empty),
      .pop             (pop),
      .rsp_pos_x       (rsp_pos_x),
      .rsp_pos_y       (rsp_pos_y),
      .rsp_tex_u       (rsp_tex_u),
      .rsp_tex_v       (rsp_tex_v),
      .rsp_last_vertex (rsp_last_vertex)
   );

endmodule

### design/sqvs_checker.sv
// port-level checks for the sprite quad vertex setup block, bound to the top level
`include "sprite_quad_vertex_setup_assert.svh"

module sqvs_checker #(
   parameter int COORD_BITS = 12
) (
   input logic                              clock,
   input logic                              reset,
   input logic                              full,
   input logic                              empty,
   input logic                              pop,
   input logic signed [sqvs_pkg::POS_W-1:0] rsp_pos_x,
   input logic signed [sqvs_pkg::POS_W-1:0] rsp_pos_y,
   input logic [COORD_BITS:0]               rsp_tex_u,
   input logic [COORD_BITS:0]               rsp_tex_v,
   input logic                              rsp_last_vertex
);

   // whole result payload as one vector
   logic [2*sqvs_pkg::POS_W+2*COORD_BITS+2:0] rsp_payload;

   assign rsp_payload = {rsp_pos_x, rsp_pos_y, rsp_tex_u, rsp_tex_v, rsp_last_vertex};

   // reset leaves no results and room for requests
   `SQVS_ASSERT_AFTER_RESET(a_reset_idle, clock, reset, (empty && !full))

   // a waiting result that is not taken stays
   `SQVS_ASSERT_NEXT(a_result_held, clock, reset, (!empty && !pop), (!empty))

   // and its payload does not change
   `SQVS_ASSERT_NEXT(a_payload_held, clock, reset, (!empty && !pop), ($stable(rsp_payload)))

   // once the last vertex of a tile is taken, the next waiting vertex is not a last one
   `SQVS_ASSERT_NEXT(a_last_then_first, clock, reset, (!empty && pop && rsp_last_vertex), (empty || !rsp_last_vertex))

endmodule

bind sprite_quad_vertex_setup sqvs_checker #(.COORD_BITS(COORD_BITS)) u_sqvs_checker (
   .clock           (clock),
   .reset           (reset),
   .full            (full),
   .empty           (empty),
   .pop             (pop),
   .rsp_pos_x       (rsp_pos_x),
   .rsp_pos_y       (rsp_pos_y),
   .rsp_tex_u       (rsp_tex_u),
   .rsp_tex_v       (rsp_tex_v),
   .rsp_last_vertex (rsp_last_vertex)
);
